### hw/rtl/scpa_pkg.sv
// Shared types, codes and constants of the size-class pool allocator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package scpa_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_POOLS           = 6;
  localparam int DEF_MAX_BLOCKS      = 4096;
  localparam int DEF_MIN_BLOCK_BYTES = 8;

  // Configuration register file: six pool block counts.
  localparam int REG_W     = 13;
  localparam int REG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam logic [REG_W-1:0] CFG_RESET = 13'd4096;

  // Fixed field widths.
  localparam int SIZE_W    = 32;
  localparam int FADDR_W   = 32;
  localparam int POOL_ID_W = 3;
  localparam int BADDR_W   = 21;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_GRANTED   = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_NOT_POOL  = 3'd4
  } status_t;

  // One request transaction.
  typedef struct packed {
    logic               cmd;
    logic [SIZE_W-1:0]  req_size;
    logic [FADDR_W-1:0] free_addr;
  } req_item_t;

  // One response transaction.
  typedef struct packed {
    status_t              status;
    logic [POOL_ID_W-1:0] pool_index;
    logic [BADDR_W-1:0]   block_addr;
  } rsp_item_t;

  // Status of the layout unit toward the control logic.
  typedef struct packed {
    logic busy;
    logic clear_lists;
  } layout_status_t;

  // Number of trailing zero bits of a positive constant.
  function automatic int trailing_zeros(input int v);
    int n;
    n = 0;
    for (int i = 0; i < 31; i++) begin
      if (v[i] == 1'b0 && n == i) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/size_class_pool_allocator.sv
// Size-class pool allocator. An allocate passes through a pop state, where the
// link memory is read for a pop, and the final state. A free passes through
// offset, reciprocal divide, correct and push, and result; misses and oversized
// requests go straight to the result. One transaction is worked at a time, the
// next taken as the current one leaves. After reset and each register write the
// pool bounds are rebuilt, during which no request is taken. Depends on scpa_pkg.
`default_nettype none

module size_class_pool_allocator #(
  parameter int POOLS           = scpa_pkg::DEF_POOLS,
  parameter int MAX_BLOCKS      = scpa_pkg::DEF_MAX_BLOCKS,
  parameter int MIN_BLOCK_BYTES = scpa_pkg::DEF_MIN_BLOCK_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  scpa_pkg::req_item_t            req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output scpa_pkg::rsp_item_t            rsp_data,
  input  logic                           cfg_write,
  input  logic [scpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpa_pkg::REG_W-1:0]     cfg_data
);
  import scpa_pkg::*;

  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PSEL_W = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam longint AREA_MAX = longint'(MAX_BLOCKS) * longint'(MIN_BLOCK_BYTES)
                                * ((longint'(1) << POOLS) - 1);
  localparam int AREA_W = $clog2(AREA_MAX + 1);
  localparam int TZ     = trailing_zeros(MIN_BLOCK_BYTES);
  localparam int D_ODD  = MIN_BLOCK_BYTES >> TZ;
  localparam int XW     = $clog2(longint'(MAX_BLOCKS) * longint'(D_ODD));
  localparam int RS     = XW + $clog2(D_ODD) + 1;
  localparam longint RECIP = (longint'(1) << RS) / D_ODD;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = XW + RW;
  localparam int MEM_DEPTH = POOLS * MAX_BLOCKS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP  = 6'b000010,
    S_OFFS = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t            state;
  layout_status_t    lay_st;
  logic [CNT_W-1:0]  pool_cap [POOLS];
  logic [AREA_W-1:0] bound [POOLS+1];

  // Free list heads (block index + 1, zero is empty) and bump pointers.
  logic [CNT_W-1:0]  freed_head [POOLS];
  logic [CNT_W-1:0]  untouched [POOLS];

  // Item under work.
  logic [PSEL_W-1:0] item_pool;
  status_t           item_status;
  logic [31:0]       item_addr;
  logic              pop;
  logic [AREA_W-1:0] prod;
  logic [XW-1:0]     x_val;
  logic [BLK_W-1:0]  q0;

  // Link memory ports.
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_raddr;
  logic [CNT_W-1:0]  mem_rdata;

  logic              take;
  logic              fin_go;
  logic [PSEL_W-1:0] alloc_pool;
  logic              too_large;
  logic [PSEL_W-1:0] free_pool;
  logic              free_hit;
  logic [CNT_W-1:0]  head_cur;
  logic [CNT_W-1:0]  head_dec;
  logic [CNT_W-1:0]  bump_cur;
  logic              bump_ok;
  logic [BLK_W-1:0]  pop_blk;
  logic [BLK_W-1:0]  sel_blk;
  logic [MEM_AW-1:0] pool_ofs;
  logic [AREA_W-1:0] blk_prod;
  logic [31:0]       off;
  logic [PW-1:0]     recip_prod;
  logic [XW-1:0]     qd0;
  logic [XW-1:0]     rem0;
  logic              fix_up;
  logic [BLK_W-1:0]  q_fin;
  logic [XW-1:0]     qd_fin;
  logic [XW-1:0]     rem_fin;
  logic [AREA_W-1:0] addr_sum;

  scpa_layout #(
    .POOLS           (POOLS),
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .CNT_W           (CNT_W),
    .AREA_W          (AREA_W),
    .PSEL_W          (PSEL_W)
  ) u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pool_cap  (pool_cap),
    .bound     (bound),
    .status    (lay_st)
  );

  scpa_link_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW),
    .DW    (CNT_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Handshake: a new transaction enters when idle or as the current one leaves.
  assign fin_go    = !rsp_valid || !rsp_stall;
  assign take      = req_valid && !req_stall;
  assign req_stall = !(!lay_st.busy && ((state == S_IDLE) || (state == S_FIN && fin_go)));

  // Classify the incoming request: size class for allocate, pool hit for free.
  always_comb begin
    alloc_pool = '0;
    free_pool  = '0;
    free_hit   = 1'b0;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if ((33'(MIN_BLOCK_BYTES) << p) >= 33'(req_data.req_size)) begin
        alloc_pool = PSEL_W'(p);
      end
      if (req_data.free_addr >= 32'(bound[p]) && req_data.free_addr < 32'(bound[p+1])) begin
        free_pool = PSEL_W'(p);
        free_hit  = 1'b1;
      end
    end
    too_large = 33'(req_data.req_size) > (33'(MIN_BLOCK_BYTES) << (POOLS - 1));
  end

  // Pop side: freed stack first, then the bump pointer.
  assign head_cur = freed_head[item_pool];
  assign head_dec = head_cur - CNT_W'(1);
  assign bump_cur = untouched[item_pool];
  assign bump_ok  = bump_cur < pool_cap[item_pool];
  assign pop_blk  = (32'(head_dec) > 32'(MAX_BLOCKS - 1)) ? BLK_W'(MAX_BLOCKS - 1)
                                                           : BLK_W'(head_dec);
  assign sel_blk  = (head_cur != '0) ? pop_blk : BLK_W'(bump_cur);
  assign pool_ofs = MEM_AW'(item_pool) * MEM_AW'(MAX_BLOCKS);
  assign blk_prod = (AREA_W'(sel_blk) * AREA_W'(MIN_BLOCK_BYTES)) << item_pool;

  // Free side: offset in the pool, divided by the odd part of the block size
  // through a reciprocal, then corrected by one compare and subtract.
  assign off        = item_addr - 32'(bound[item_pool]);
  assign recip_prod = PW'(x_val) * PW'(RECIP);
  assign qd0        = XW'(q0) * XW'(D_ODD);
  assign rem0       = x_val - qd0;
  assign fix_up     = rem0 >= XW'(D_ODD);
  assign q_fin      = fix_up ? q0 + BLK_W'(1) : q0;
  assign qd_fin     = fix_up ? qd0 + XW'(D_ODD) : qd0;
  assign rem_fin    = fix_up ? rem0 - XW'(D_ODD) : rem0;

  // Link memory accesses: read on a pop, write on a push.
  assign mem_re    = (state == S_POP) && (head_cur != '0);
  assign mem_raddr = pool_ofs + MEM_AW'(pop_blk);
  assign mem_we    = (state == S_FIX);
  assign mem_waddr = pool_ofs + MEM_AW'(q_fin);
  assign mem_wdata = head_cur;

  assign addr_sum = bound[item_pool] + prod;

  // Control: state, list heads, bump pointers and the response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int p = 0; p < POOLS; p++) begin
        freed_head[p] <= '0;
        untouched[p]  <= '0;
      end
    end else begin
      if (lay_st.clear_lists) begin
        for (int p = 0; p < POOLS; p++) begin
          freed_head[p] <= '0;
          untouched[p]  <= '0;
        end
      end else begin
        if (state == S_POP && head_cur == '0 && bump_ok) begin
          untouched[item_pool] <= bump_cur + CNT_W'(1);
        end
        if (state == S_FIX) begin
          freed_head[item_pool] <= CNT_W'(q_fin) + CNT_W'(1);
        end
        if (state == S_FIN && fin_go && pop) begin
          freed_head[item_pool] <= mem_rdata;
        end
      end

      if (state == S_FIN && fin_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (take) begin
        if (req_data.cmd == CMD_ALLOC) begin
          state <= too_large ? S_FIN : S_POP;
        end else begin
          state <= free_hit ? S_OFFS : S_FIN;
        end
      end else begin
        unique case (state)
          S_IDLE:  state <= S_IDLE;
          S_POP:   state <= S_FIN;
          S_OFFS:  state <= S_DIV;
          S_DIV:   state <= S_FIX;
          S_FIX:   state <= S_FIN;
          S_FIN:   state <= fin_go ? S_IDLE : S_FIN;
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Datapath registers of the transaction under work and the response.
  always_ff @(posedge clk) begin
    if (take) begin
      item_addr <= req_data.free_addr;
      pop       <= 1'b0;
      prod      <= '0;
      if (req_data.cmd == CMD_ALLOC) begin
        item_pool   <= too_large ? PSEL_W'(0) : alloc_pool;
        item_status <= too_large ? STAT_TOO_LARGE : STAT_GRANTED;
      end else begin
        item_pool   <= free_pool;
        item_status <= free_hit ? STAT_FREED : STAT_NOT_POOL;
      end
    end else begin
      unique case (state)
        S_POP: begin
          pop  <= (head_cur != '0);
          prod <= blk_prod;
          if (head_cur == '0 && !bump_ok) begin
            item_status <= STAT_EMPTY;
          end
        end
        S_OFFS: x_val <= XW'(off >> (TZ + int'(item_pool)));
        S_DIV:  q0    <= BLK_W'(recip_prod >> RS);
        S_FIX:  prod  <= AREA_W'(qd_fin) << (TZ + int'(item_pool));
        S_IDLE, S_FIN: begin
        end
        default: begin
        end
      endcase
    end

    if (state == S_FIN && fin_go) begin
      rsp_data.status     <= item_status;
      rsp_data.pool_index <= POOL_ID_W'(item_pool);
      if (item_status == STAT_GRANTED || item_status == STAT_FREED) begin
        rsp_data.block_addr <= BADDR_W'(addr_sum);
      end else begin
        rsp_data.block_addr <= '0;
      end
    end
  end

  // A register write rebuilds the layout, so the next cycle takes no request.
  a_cfg_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index < CFG_IDX_W'(REG_COUNT)) |=> req_stall)
    else $error("request taken right after a register write");

  // A response only appears out of the final state.
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FIN))
    else $error("response raised outside the final state");

  // The corrected quotient leaves a remainder below the divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> (rem_fin < XW'(D_ODD)))
    else $error("reciprocal divide out of range");

endmodule

`default_nettype wire

### hw/rtl/scpa_layout.sv
// Configuration registers and pool layout of the size-class pool allocator.
// Holds the block counts and rebuilds the pool end addresses one pool per cycle.
// Depends on scpa_pkg.
`default_nettype none

module scpa_layout #(
  parameter int POOLS           = scpa_pkg::DEF_POOLS,
  parameter int MAX_BLOCKS      = scpa_pkg::DEF_MAX_BLOCKS,
  parameter int MIN_BLOCK_BYTES = scpa_pkg::DEF_MIN_BLOCK_BYTES,
  parameter int CNT_W           = 13,
  parameter int AREA_W          = 21,
  parameter int PSEL_W          = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scpa_pkg::REG_W-1:0]        cfg_data,
  output logic [CNT_W-1:0]                  pool_cap [POOLS],
  output logic [AREA_W-1:0]                 bound [POOLS+1],
  output scpa_pkg::layout_status_t          status
);
  import scpa_pkg::*;

  logic [REG_W-1:0]  count_reg [POOLS];
  logic [AREA_W-1:0] bound_hi [POOLS];
  logic [AREA_W-1:0] acc;
  logic [AREA_W-1:0] acc_next;
  logic [PSEL_W-1:0] sweep_idx;
  logic              busy;
  logic              cfg_hit;

  // A write to any listed register changes the layout and empties the lists.
  assign cfg_hit = cfg_write && (cfg_index < CFG_IDX_W'(REG_COUNT));

  assign status.busy        = busy;
  assign status.clear_lists = cfg_hit;

  // Counts above the pool capacity saturate at the capacity.
  always_comb begin
    for (int i = 0; i < POOLS; i++) begin
      pool_cap[i] = (32'(count_reg[i]) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                           : CNT_W'(count_reg[i]);
    end
  end

  // Pool i spans bound[i] up to bound[i+1].
  always_comb begin
    bound[0] = '0;
    for (int i = 0; i < POOLS; i++) begin
      bound[i+1] = bound_hi[i];
    end
  end

  // Running sum of pool sizes during the sweep.
  assign acc_next = acc + ((AREA_W'(pool_cap[sweep_idx]) * AREA_W'(MIN_BLOCK_BYTES))
                           << sweep_idx);

  // Register writes and the sweep that rebuilds the pool bounds.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOLS; i++) begin
        count_reg[i] <= CFG_RESET;
      end
      busy      <= 1'b1;
      sweep_idx <= '0;
      acc       <= '0;
    end else if (cfg_hit) begin
      if (32'(cfg_index) < 32'(POOLS)) begin
        count_reg[cfg_index[PSEL_W-1:0]] <= cfg_data;
      end
      busy      <= 1'b1;
      sweep_idx <= '0;
      acc       <= '0;
    end else if (busy) begin
      bound_hi[sweep_idx] <= acc_next;
      acc                 <= acc_next;
      if (32'(sweep_idx) == 32'(POOLS - 1)) begin
        busy <= 1'b0;
      end else begin
        sweep_idx <= sweep_idx + PSEL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scpa_link_ram.sv
// Link memory of the size-class pool allocator: one write and one read port,
// registered read data. Holds the next-block links of all free lists.
// Depends on scpa_pkg.
`default_nettype none

module scpa_link_ram #(
  parameter int DEPTH = 24576,
  parameter int AW    = 15,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  import scpa_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
